FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge once reset is released.
`define CRLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition seen at one edge implies another at the next edge.
`define CRLE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: hw/rtl/crle_pkg.sv
`default_nettype none

package crle_pkg;

  // Run counter width; results carry the same width.
  localparam int CountBits = 32;

  // Item modes
  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_COLUMN = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // Result operation codes
  localparam logic [2:0] OP_CLIP   = 3'd0;
  localparam logic [2:0] OP_MATCH  = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_EMPTY  = 3'd4;

  // Gap character '-'
  localparam logic [7:0] GAP_CHAR = 8'd45;

  // Result queue depth and pointer width
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [1:0]           mode;
    logic [7:0]           ref_char;
    logic [7:0]           query_char;
    logic [CountBits-1:0] qry_start;
    logic [CountBits-1:0] qry_end;
    logic [CountBits-1:0] query_total;
  } item_t;

  typedef struct packed {
    logic [2:0]           op_code;
    logic [CountBits-1:0] run_length;
    logic                 last;
  } result_t;

  // Pushes from the core into the result queue; second only with first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crle_in_reg.sv
`default_nettype none

module crle_in_reg
  import crle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       item_valid,
  output item_t      item
);

  logic  hold_v_r;
  logic  hold_v_nxt;
  item_t item_r;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready = !hold_v_r || take;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (take) begin
      hold_v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = hold_v_r;
  assign item       = item_r;

endmodule

`default_nettype wire

FILE: hw/rtl/crle_core.sv
`default_nettype none

module crle_core
  import crle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  take,
  input  wire item_t item,
  output push_t      push,
  output result_t    res0,
  output result_t    res1
);

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] CountOne = {{(CountBits-1){1'b0}}, 1'b1};

  logic [1:0]           open_op_r;
  logic [1:0]           open_op_nxt;
  logic [CountBits-1:0] open_count_r;
  logic [CountBits-1:0] open_count_nxt;

  logic [1:0]           col_op;
  logic                 run_open;
  logic [CountBits:0]   span;
  logic [CountBits-1:0] tail;
  logic                 has_tail;
  result_t              run_res;
  result_t              tail_res;

  // Classify the column
  always_comb begin
    if (item.ref_char == GAP_CHAR) begin
      col_op = OP_INSERT[1:0];
    end else if (item.query_char == GAP_CHAR) begin
      col_op = OP_DELETE[1:0];
    end else begin
      col_op = OP_MATCH[1:0];
    end
  end

  assign run_open = (open_count_r != '0);

  // Trailing clip: total - end - 1, zero unless total exceeds end + 1
  assign span     = {1'b0, item.query_total} - {1'b0, item.qry_end};
  assign has_tail = !span[CountBits] && (span[CountBits-1:0] > CountOne);
  assign tail     = span[CountBits-1:0] - CountOne;

  assign run_res.op_code     = {1'b0, open_op_r};
  assign run_res.run_length  = open_count_r;
  assign run_res.last        = 1'b0;
  assign tail_res.op_code    = OP_CLIP;
  assign tail_res.run_length = tail;
  assign tail_res.last       = 1'b1;

  // Decide results and the next open run
  always_comb begin
    open_op_nxt    = open_op_r;
    open_count_nxt = open_count_r;
    push           = '0;
    res0           = run_res;
    res1           = tail_res;
    case (item.mode)
      MODE_BEGIN: begin
        open_op_nxt    = OP_CLIP[1:0];
        open_count_nxt = item.qry_start;
      end
      MODE_COLUMN: begin
        if (run_open && (col_op == open_op_r)) begin
          if (open_count_r != CountMax) begin
            open_count_nxt = open_count_r + CountOne;
          end
        end else begin
          push.first     = run_open;
          open_op_nxt    = col_op;
          open_count_nxt = CountOne;
        end
      end
      MODE_END: begin
        push.first     = 1'b1;
        open_op_nxt    = OP_CLIP[1:0];
        open_count_nxt = '0;
        if (run_open) begin
          res0.last   = !has_tail;
          push.second = has_tail;
        end else if (has_tail) begin
          res0 = tail_res;
        end else begin
          res0.op_code    = OP_EMPTY;
          res0.run_length = '0;
          res0.last       = 1'b1;
        end
      end
      default: begin
        // drop unused mode
      end
    endcase
    if (!take) begin
      push           = '0;
      open_op_nxt    = open_op_r;
      open_count_nxt = open_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_op_r    <= OP_CLIP[1:0];
      open_count_r <= '0;
    end else begin
      open_op_r    <= open_op_nxt;
      open_count_r <= open_count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crle_out_queue.sv
`default_nettype none

module crle_out_queue
  import crle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire push_t   push,
  input  wire result_t res0,
  input  wire result_t res1,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  result_t              mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r;
  logic [QueuePtrW-1:0] wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r;
  logic [QueuePtrW-1:0] rd_ptr_nxt;
  logic [QueuePtrW:0]   count_r;
  logic [QueuePtrW:0]   count_nxt;
  logic [QueuePtrW:0]   n_push;
  logic                 pop;

  // Room for the two results an end item can bring
  assign room      = (count_r <= (QueuePtrW + 1)'(QueueDepth - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign n_push = (QueuePtrW + 1)'(push.first) + (QueuePtrW + 1)'(push.second);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[QueuePtrW-1:0];
    rd_ptr_nxt = rd_ptr_r + QueuePtrW'(pop);
    count_nxt  = count_r + n_push - (QueuePtrW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results in order
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push.second) begin
      mem_r[wr_ptr_r + QueuePtrW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cigar_run_length_encoder.sv
// Chan | Dir | Handshake           | Payload
// in   | in  | in_valid/in_ready   | mode, ref_char, query_char, qry_start, qry_end, query_total
// out  | out | out_valid/out_ready | op_code, run_length, last
//
// An item is registered on transfer and processed once the result queue has room
// for its results; its results are written into the result queue, from which they transfer.
// One item per cycle is sustained while items average at most one result and
// out_ready stays high; an end item can place two results in the four-entry result
// queue, and items stall only while fewer than two entries are free there.
// Synchronous active-low reset clears the open run and empties the queue.
`default_nettype none

module cigar_run_length_encoder
  import crle_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_mode,
  input  wire logic [7:0]           in_ref_char,
  input  wire logic [7:0]           in_query_char,
  input  wire logic [CountBits-1:0] in_qry_start,
  input  wire logic [CountBits-1:0] in_qry_end,
  input  wire logic [CountBits-1:0] in_query_total,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_op_code,
  output logic [CountBits-1:0]      out_run_length,
  output logic                      out_last
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    room;
  logic    take;
  push_t   push;
  result_t res0;
  result_t res1;
  result_t out_res;

  assign in_item.mode        = in_mode;
  assign in_item.ref_char    = in_ref_char;
  assign in_item.query_char  = in_query_char;
  assign in_item.qry_start   = in_qry_start;
  assign in_item.qry_end     = in_qry_end;
  assign in_item.query_total = in_query_total;

  // Process the held item when the queue can take its results
  assign take = item_valid && room;

  crle_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  crle_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .push  (push),
    .res0  (res0),
    .res1  (res1)
  );

  crle_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_op_code    = out_res.op_code;
  assign out_run_length = out_res.run_length;
  assign out_last       = out_res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/crle_checker.sv
`default_nettype none
`include "assert_macros.svh"

module crle_checker
  import crle_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_op_code,
  input wire logic [CountBits-1:0] out_run_length,
  input wire logic                 out_last
);

  // Hold a stalled result
  `CRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
  `CRLE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_op_code) && $stable(out_run_length) && $stable(out_last), "stalled result changed")
  // Only defined operation codes leave the block
  `CRLE_ASSERT(a_op_range, !out_valid || (out_op_code <= OP_EMPTY), "undefined operation code")
  // The empty marker is a zero-length final result
  `CRLE_ASSERT(a_empty_form, !(out_valid && (out_op_code == OP_EMPTY)) || ((out_run_length == '0) && out_last), "malformed empty marker")
  // Every real run has a nonzero length
  `CRLE_ASSERT(a_run_nonzero, !(out_valid && (out_op_code != OP_EMPTY)) || (out_run_length != '0), "zero-length run")

endmodule

bind cigar_run_length_encoder crle_checker u_crle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_op_code    (out_op_code),
  .out_run_length (out_run_length),
  .out_last       (out_last)
);

`default_nettype wire

FILE: tb/tb_cigar_run_length_encoder.sv
`timescale 1ns / 100ps

import crle_pkg::*;

// Tracks the open run of the current alignment and queues the runs it must emit.
class cigar_scoreboard;
  logic [2:0]           open_op;
  logic [CountBits-1:0] open_count;
  bit                   any_emitted;
  result_t              expected_runs[$];
  int                   mismatches;

  function new();
    open_op     = OP_CLIP;
    open_count  = '0;
    any_emitted = 1'b0;
    mismatches  = 0;
  endfunction

  function int pending();
    return expected_runs.size();
  endfunction

  function void push_run(logic [2:0] op, logic [CountBits-1:0] len, logic is_last);
    result_t run;
    run.op_code    = op;
    run.run_length = len;
    run.last       = is_last;
    expected_runs.insert(expected_runs.size(), run);
  endfunction

  // Advance the predicted state by one accepted input transfer.
  function void note_item(logic [1:0] mode, logic [7:0] ref_c, logic [7:0] query_c,
                          logic [CountBits-1:0] q_start, logic [CountBits-1:0] q_end,
                          logic [CountBits-1:0] q_total);
    logic [2:0]           col_op;
    logic [CountBits-1:0] tail_len;
    logic [CountBits:0]   end_next;
    int                   emitted;
    case (mode)
      MODE_BEGIN: begin
        // Drop any unfinished alignment; hold the leading clip as the open run
        open_op     = OP_CLIP;
        open_count  = q_start;
        any_emitted = (q_start != 0);
      end
      MODE_COLUMN: begin
        if (ref_c == GAP_CHAR) col_op = OP_INSERT;
        else if (query_c == GAP_CHAR) col_op = OP_DELETE;
        else col_op = OP_MATCH;
        if (open_count != 0 && col_op == open_op) begin
          if (open_count != {CountBits{1'b1}}) open_count = open_count + 1'b1;
        end else begin
          if (open_count != 0) push_run(open_op, open_count, 1'b0);
          open_op    = col_op;
          open_count = 1;
        end
        any_emitted = 1'b1;
      end
      MODE_END: begin
        // Trailing clip is zero when the query ends at or before the end offset
        end_next = {1'b0, q_end} + 1'b1;
        tail_len = ({1'b0, q_total} > end_next) ? q_total - q_end - 1'b1 : '0;
        emitted  = 0;
        if (open_count != 0) begin
          push_run(open_op, open_count, tail_len == 0);
          emitted++;
        end
        if (tail_len != 0) begin
          push_run(OP_CLIP, tail_len, 1'b1);
          emitted++;
        end
        if (emitted == 0) push_run(OP_EMPTY, '0, 1'b1);
        open_op     = OP_CLIP;
        open_count  = '0;
        any_emitted = 1'b0;
      end
      default: begin
        // unused mode: no result, state unchanged
      end
    endcase
  endfunction

  // Compare one output transfer against the oldest predicted run.
  function void check_result(logic [2:0] op, logic [CountBits-1:0] len, logic is_last);
    result_t want;
    if (expected_runs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected run op=%0d len=%0d last=%0b", op, len, is_last);
      return;
    end
    want = expected_runs.pop_front();
    if (op !== want.op_code || len !== want.run_length || is_last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: run mismatch exp op=%0d len=%0d last=%0b, got op=%0d len=%0d last=%0b",
                 want.op_code, want.run_length, want.last, op, len, is_last);
    end
  endfunction
endclass

module tb_cigar_run_length_encoder;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int ItemTarget = 1400;
  localparam int IdleLimit  = 3000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_mode;
  logic [7:0]           in_ref_char;
  logic [7:0]           in_query_char;
  logic [CountBits-1:0] in_qry_start;
  logic [CountBits-1:0] in_qry_end;
  logic [CountBits-1:0] in_query_total;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_op_code;
  logic [CountBits-1:0] out_run_length;
  logic                 out_last;

  cigar_scoreboard sb;
  int burst_left;
  int items_sent;
  int idle_cycles;
  int stall_phase;
  int stall_left;
  int stall_tick;

  cigar_run_length_encoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_ref_char   (in_ref_char),
    .in_query_char (in_query_char),
    .in_qry_start  (in_qry_start),
    .in_qry_end    (in_qry_end),
    .in_query_total(in_query_total),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_op_code   (out_op_code),
    .out_run_length(out_run_length),
    .out_last      (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: switch at random between stall styles
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_phase = $urandom_range(3);
      stall_left  = $urandom_range(300, 50);
    end
    stall_left--;
    stall_tick++;
    case (stall_phase)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(9) > 2);
      2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ((stall_tick % 4) != 0);
    endcase
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_op_code, out_run_length, out_last);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Drive one item in bursts with random gaps; wait for its transfer.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] ref_c,
                           input logic [7:0] query_c, input logic [CountBits-1:0] q_start,
                           input logic [CountBits-1:0] q_end,
                           input logic [CountBits-1:0] q_total);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 1) : $urandom_range(4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_ref_char    <= ref_c;
    in_query_char  <= query_c;
    in_qry_start   <= q_start;
    in_qry_end     <= q_end;
    in_query_total <= q_total;
    do @(posedge clk); while (!in_ready);
    sb.note_item(mode, ref_c, query_c, q_start, q_end, q_total);
    if (mode != ModeUnused) items_sent++;
  endtask

  function automatic logic [7:0] non_gap_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == GAP_CHAR);
    return c;
  endfunction

  task automatic send_column(input logic [2:0] op);
    logic [7:0] ref_c;
    logic [7:0] query_c;
    case (op)
      OP_INSERT: begin
        ref_c   = GAP_CHAR;
        query_c = 8'($urandom_range(255));
      end
      OP_DELETE: begin
        ref_c   = non_gap_char();
        query_c = GAP_CHAR;
      end
      default: begin
        ref_c   = non_gap_char();
        query_c = non_gap_char();
      end
    endcase
    send_item(MODE_COLUMN, ref_c, query_c, $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_begin(input logic [CountBits-1:0] q_start);
    send_item(MODE_BEGIN, 8'($urandom_range(255)), 8'($urandom_range(255)), q_start,
              $urandom(), $urandom());
  endtask

  task automatic send_end(input logic [CountBits-1:0] q_end, input logic [CountBits-1:0] q_total);
    send_item(MODE_END, 8'($urandom_range(255)), 8'($urandom_range(255)), $urandom(), q_end,
              q_total);
  endtask

  task automatic send_ignored();
    send_item(ModeUnused, 8'($urandom_range(255)), 8'($urandom_range(255)), $urandom(),
              $urandom(), $urandom());
  endtask

  function automatic logic [2:0] pick_op();
    case ($urandom_range(2))
      0: return OP_MATCH;
      1: return OP_INSERT;
      default: return OP_DELETE;
    endcase
  endfunction

  function automatic logic [CountBits-1:0] pick_start();
    case ($urandom_range(5))
      0, 1: return '0;
      2, 3: return $urandom_range(50, 1);
      4: return $urandom();
      default: return {CountBits{1'b1}};
    endcase
  endfunction

  // End offsets covering no tail, short tails, wrap-around and the extremes
  task automatic send_random_end();
    logic [CountBits-1:0] q_end;
    q_end = $urandom_range(1000);
    case ($urandom_range(6))
      0: send_end(q_end, q_end + 1);
      1: send_end(q_end, q_end + $urandom_range(30, 2));
      2: send_end(q_end, $urandom_range(q_end));
      3: send_end($urandom(), $urandom());
      4: send_end({CountBits{1'b1}}, $urandom());
      5: send_end($urandom_range(3), {CountBits{1'b1}});
      default: send_end(q_end, q_end + $urandom_range(4));
    endcase
  endtask

  // One alignment; a few are malformed on purpose
  task automatic run_alignment();
    int kind;
    int num_runs;
    int run_len;
    logic [2:0] op;
    kind = $urandom_range(9);
    if (kind != 1) send_begin(pick_start());
    if (kind == 0) begin
      // abandon a partial alignment with a second begin
      repeat ($urandom_range(4, 1)) send_column(pick_op());
      send_begin(pick_start());
    end
    if (kind != 2) begin
      num_runs = $urandom_range(5, 1);
      repeat (num_runs) begin
        op = pick_op();
        run_len = ($urandom_range(49) == 0) ? $urandom_range(300, 100) : $urandom_range(8, 1);
        repeat (run_len) send_column(op);
        if (kind == 3 && $urandom_range(1) == 0) send_ignored();
      end
    end
    send_random_end();
    if (kind == 2 && $urandom_range(1) == 0) send_random_end();
  endtask

  // Hold the sender until every predicted run has been seen
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int next_pause;
    sb             = new();
    burst_left     = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    stall_phase    = 0;
    stall_left     = 0;
    stall_tick     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_BEGIN;
    in_ref_char    = '0;
    in_query_char  = '0;
    in_qry_start   = '0;
    in_qry_end     = '0;
    in_query_total = '0;
    out_ready      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // End with nothing open, then an empty alignment with no tail
    send_end('0, '0);
    send_begin('0);
    send_end(32'd9, 32'd10);
    // Leading clip flushed by the end item
    send_begin(32'd7);
    send_end('0, 32'd1);
    // Max leading clip, every operation, merged gap column, ignored mode
    send_begin({CountBits{1'b1}});
    send_item(MODE_COLUMN, 8'h41, 8'h43, '0, '0, '0);
    send_item(MODE_COLUMN, GAP_CHAR, 8'h47, '0, '0, '0);
    send_item(MODE_COLUMN, GAP_CHAR, GAP_CHAR, '0, '0, '0);
    send_item(MODE_COLUMN, 8'h54, GAP_CHAR, '0, '0, '0);
    send_ignored();
    send_end({CountBits{1'b1}}, {CountBits{1'b1}});
    // Column without a begin, largest trailing clip
    send_item(MODE_COLUMN, 8'h00, 8'hff, {CountBits{1'b1}}, {CountBits{1'b1}},
              {CountBits{1'b1}});
    send_end('0, {CountBits{1'b1}});
    // Begin while open discards it; query total below end offset
    send_begin(32'd3);
    send_begin('0);
    send_item(MODE_COLUMN, 8'hff, GAP_CHAR, '0, '0, '0);
    send_end(32'd5, 32'd4);
    wait_drained();

    next_pause = items_sent + 350;
    while (items_sent < ItemTarget) begin
      run_alignment();
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause = items_sent + 350;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
